// File: rtl/core/tnbk_pkg.sv
// ---------------------------------------------------------------------------
// tnbk_pkg: shared types for the top-n bid keeper
// result kinds, request codes, stored entry and result beat layout
// ---------------------------------------------------------------------------
package tnbk_pkg;

	localparam int unsigned TAG_W    = 16;
	localparam int unsigned PRICE_W  = 32;
	localparam int unsigned REV_W    = 37;
	localparam int unsigned UNITS_W  = 6;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned S_DATA_W = 48;
	localparam int unsigned M_DATA_W = 96;

	localparam logic [UNITS_W-1:0] UNITS_RESET = 6'd32;

	// request codes on the input tuser
	localparam logic REQ_OFFER = 1'b0;
	localparam logic REQ_CLOSE = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPTED = 3'd0,
		KIND_REJECTED = 3'd1,
		KIND_OUTBID   = 3'd2,
		KIND_WINNER   = 3'd3,
		KIND_SUMMARY  = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_EVICT,
		ST_INSERT,
		ST_RES_MAIN,
		ST_RES_OUTBID,
		ST_CL_READ,
		ST_CL_EMIT,
		ST_CL_SUM
	} state_t;

	// one stored bid
	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	// one result beat
	typedef struct packed {
		kind_t              kind;
		logic [TAG_W-1:0]   tag;
		logic [PRICE_W-1:0] price;
		logic [REV_W-1:0]   revenue;
		logic [UNITS_W-1:0] unsold;
		logic               last;
	} res_t;

endpackage

// File: rtl/core/tnbk_store.sv
// ---------------------------------------------------------------------------
// tnbk_store: sorted bid memory
// one write port and one read port, read data registered
// ---------------------------------------------------------------------------
module tnbk_store
	import tnbk_pkg::*;
#(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/tnbk_seq.sv
// ---------------------------------------------------------------------------
// tnbk_seq: request sequencer
// walks the sorted memory to insert or evict, and reads it out at close
// ---------------------------------------------------------------------------
module tnbk_seq
	import tnbk_pkg::*;
#(
	parameter int unsigned MAX_UNITS = 32,
	parameter int unsigned AW        = 5,
	parameter int unsigned CW        = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [UNITS_W-1:0] units,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_req,
	input  logic [TAG_W-1:0]   in_tag,
	input  logic [PRICE_W-1:0] in_price,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output entry_t             mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  entry_t             mem_rdata,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res,
	output logic [CW-1:0]      held_count
);

	localparam logic [UNITS_W:0] MAX_EXT = (UNITS_W+1)'(MAX_UNITS);

	state_t state_q, state_d;

	logic [TAG_W-1:0]   tag_q;
	logic [PRICE_W-1:0] price_q;
	logic               rejected_q;
	logic               evict_q;
	entry_t             ev_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      count_q;
	logic [REV_W-1:0]   rev_q;

	logic [UNITS_W:0] units_ext;
	logic [UNITS_W:0] count_ext;
	logic [UNITS_W:0] cap_ext;
	logic             full;
	logic             cap_zero;
	logic [UNITS_W-1:0] unsold;
	logic             gt;
	logic [CW:0]      idx_p1;
	logic [CW:0]      idx_p2;
	logic [CW:0]      idx_m2;
	logic [CW:0]      cnt_m1;
	logic [CW:0]      raddr_full;
	logic             above_ok;
	logic             below_ok;
	entry_t           new_entry;

	// capacity, fullness and unsold units
	assign units_ext = {1'b0, units};
	assign count_ext = (UNITS_W+1)'(count_q);
	assign cap_ext   = (units_ext < MAX_EXT) ? units_ext : MAX_EXT;
	assign full      = count_ext >= cap_ext;
	assign cap_zero  = cap_ext == '0;
	assign unsold    = (units_ext > count_ext) ? UNITS_W'(units_ext - count_ext) : '0;

	// walk arithmetic and price compare against the entry just read
	assign gt        = price_q > mem_rdata.price;
	assign idx_p1    = {1'b0, idx_q} + (CW+1)'(1);
	assign idx_p2    = {1'b0, idx_q} + (CW+1)'(2);
	assign idx_m2    = {1'b0, idx_q} - (CW+1)'(2);
	assign cnt_m1    = {1'b0, count_q} - (CW+1)'(1);
	assign above_ok  = (idx_p1 < {1'b0, count_q}) && gt;
	assign below_ok  = (idx_q != '0) && !gt;
	assign new_entry = '{price: price_q, tag: tag_q};

	assign mem_raddr  = raddr_full[AW-1:0];
	assign held_count = count_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory commands and result beat
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = idx_q[AW-1:0];
		mem_wdata  = new_entry;
		mem_re     = 1'b0;
		raddr_full = '0;
		res_valid  = 1'b0;
		res        = '{kind: KIND_ACCEPTED, tag: tag_q, price: price_q,
			revenue: '0, unsold: '0, last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_req == REQ_CLOSE) begin
						state_d = ST_CL_READ;
					end else if (cap_zero) begin
						state_d = ST_RES_MAIN;
					end else if (full) begin
						mem_re  = 1'b1;
						state_d = ST_CHK;
					end else begin
						mem_re     = count_q != '0;
						raddr_full = cnt_m1;
						state_d    = ST_INSERT;
					end
				end
			end
			ST_CHK: begin
				if (gt) begin
					mem_re     = 1'b1;
					raddr_full = (CW+1)'(1);
					state_d    = ST_EVICT;
				end else begin
					state_d = ST_RES_MAIN;
				end
			end
			ST_EVICT: begin
				mem_we = 1'b1;
				if (above_ok) begin
					mem_wdata  = mem_rdata;
					mem_re     = 1'b1;
					raddr_full = idx_p2;
				end else begin
					state_d = ST_RES_MAIN;
				end
			end
			ST_INSERT: begin
				mem_we = 1'b1;
				if (below_ok) begin
					mem_wdata  = mem_rdata;
					mem_re     = 1'b1;
					raddr_full = idx_m2;
				end else begin
					state_d = ST_RES_MAIN;
				end
			end
			ST_RES_MAIN: begin
				res_valid = 1'b1;
				res.kind  = rejected_q ? KIND_REJECTED : KIND_ACCEPTED;
				res.last  = !evict_q;
				if (res_ready) begin
					state_d = evict_q ? ST_RES_OUTBID : ST_IDLE;
				end
			end
			ST_RES_OUTBID: begin
				res_valid = 1'b1;
				res.kind  = KIND_OUTBID;
				res.tag   = ev_q.tag;
				res.price = ev_q.price;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_CL_READ: begin
				if (idx_q < count_q) begin
					mem_re     = 1'b1;
					raddr_full = {1'b0, idx_q};
					state_d    = ST_CL_EMIT;
				end else begin
					state_d = ST_CL_SUM;
				end
			end
			ST_CL_EMIT: begin
				res_valid = 1'b1;
				res.kind  = KIND_WINNER;
				res.tag   = mem_rdata.tag;
				res.price = mem_rdata.price;
				res.last  = 1'b0;
				if (res_ready) begin
					state_d = ST_CL_READ;
				end
			end
			ST_CL_SUM: begin
				res_valid   = 1'b1;
				res.kind    = KIND_SUMMARY;
				res.tag     = '0;
				res.price   = '0;
				res.revenue = rev_q;
				res.unsold  = unsold;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ST_INSERT && !below_ok) begin
			count_q <= count_q + CW'(1);
		end else if (state_q == ST_CL_SUM && res_ready) begin
			count_q <= '0;
		end
	end

	// request payload, walk index and close totals
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					tag_q      <= in_tag;
					price_q    <= in_price;
					evict_q    <= 1'b0;
					rejected_q <= cap_zero;
					idx_q      <= (in_req == REQ_CLOSE) ? '0 : count_q;
					rev_q      <= '0;
				end
			end
			ST_CHK: begin
				rejected_q <= !gt;
				evict_q    <= gt;
				ev_q       <= mem_rdata;
				idx_q      <= '0;
			end
			ST_EVICT: begin
				if (above_ok) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_INSERT: begin
				if (below_ok) begin
					idx_q <= idx_q - CW'(1);
				end
			end
			ST_CL_EMIT: begin
				if (res_ready) begin
					rev_q <= rev_q + REV_W'(mem_rdata.price);
					idx_q <= idx_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/top_n_bid_keeper.sv
// ---------------------------------------------------------------------------
// top_n_bid_keeper: bounded sorted store of the highest bids
// offers insert or evict in the bid memory, close reads out winners and totals
// ---------------------------------------------------------------------------
// offer: rejected at once at zero capacity; when full, compared with the lowest held bid
//   and rejected, or that bid evicted and the walk run; with room, inserted by the walk
// close: each held bid read from the memory and sent as one winner beat, then a summary
// beats leave through the output register, on the output in the cycle after it takes them
// reset clears held count, units register to 32 and the sequencer; the
//   bid memory is not cleared, entries beyond the count are never used
module top_n_bid_keeper
	import tnbk_pkg::*;
#(
	parameter int unsigned MAX_UNITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // bidder_tag[15:0], bid_price[47:16]
	input  logic [0:0]          s_tuser,  // req_type
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // tag_out, price_out, revenue, unsold_units, pad
	output logic [KIND_W-1:0]   m_tuser,  // result_kind
	output logic                m_tlast,  // last_of_run
	input  logic                cfg_we,
	input  logic [UNITS_W-1:0]  cfg_wdata // units_for_sale
);

	localparam int unsigned AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
	localparam int unsigned CW = $clog2(MAX_UNITS + 1);

	logic [UNITS_W-1:0] units_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	entry_t             mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	entry_t             mem_rdata;
	logic               res_valid;
	logic               res_ready;
	res_t               res;
	res_t               out_q;
	logic               out_valid_q;
	logic [CW-1:0]      held_count;

	// units register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_q <= UNITS_RESET;
		end else if (cfg_we) begin
			units_q <= cfg_wdata;
		end
	end

	tnbk_store #(
		.DEPTH (MAX_UNITS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tnbk_seq #(
		.MAX_UNITS (MAX_UNITS),
		.AW        (AW),
		.CW        (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.units      (units_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (s_tuser[0]),
		.in_tag     (s_tdata[15:0]),
		.in_price   (s_tdata[47:16]),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.held_count (held_count)
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {5'b0, out_q.unsold, out_q.revenue, out_q.price, out_q.tag};

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(held_count) <= MAX_UNITS)
		else $error("held count above capacity");

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat taken while busy");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_SUMMARY |-> res.last)
		else $error("close summary not last of run");

	a_winner_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_WINNER |-> !m_tlast)
		else $error("winner beat marked last");

endmodule
